@@ rtl/core/rcsm_pkg.sv @@
package rcsm_pkg;

    localparam int unsigned EMA_SHIFT_DEF = 2;
    localparam int unsigned ADC_BITS_DEF  = 12;
    localparam int unsigned AXIS_W  = 12;
    localparam int unsigned CHAN_W  = 11;
    localparam int unsigned PIN_N   = 14;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 12;
    localparam int unsigned DIV_W   = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CAL_MIN     = 3'd0,
        REG_CAL_CENTER  = 3'd1,
        REG_CAL_MAX     = 3'd2,
        REG_DEAD_BAND   = 3'd3,
        REG_CHAN_LOW    = 3'd4,
        REG_CHAN_MIDDLE = 3'd5,
        REG_CHAN_HIGH   = 3'd6,
        REG_DEBOUNCE    = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [AXIS_W-1:0] cal_min;
        logic [AXIS_W-1:0] cal_center;
        logic [AXIS_W-1:0] cal_max;
        logic [AXIS_W-1:0] dead_band;
        logic [CHAN_W-1:0] chan_low;
        logic [CHAN_W-1:0] chan_middle;
        logic [CHAN_W-1:0] chan_high;
        logic [3:0]        debounce_len;
    } cfg_t;

    // one queued job: averaged sticks and debounced pins
    typedef struct packed {
        logic [3:0][AXIS_W-1:0] avg;
        logic [PIN_N-1:0]       stable;
    } job_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SETUP,
        B_DIV,
        B_CLAMP,
        B_EMIT
    } back_state_t;

endpackage

@@ rtl/core/rcsm_if.sv @@
interface rcsm_in_if;
    logic                             valid;
    logic                             ready;
    logic [rcsm_pkg::AXIS_W-1:0]      axis_roll;
    logic [rcsm_pkg::AXIS_W-1:0]      axis_pitch;
    logic [rcsm_pkg::AXIS_W-1:0]      axis_throttle;
    logic [rcsm_pkg::AXIS_W-1:0]      axis_yaw;
    logic [rcsm_pkg::PIN_N-1:0]       pins_pressed;
    modport source (output valid, axis_roll, axis_pitch, axis_throttle, axis_yaw,
                    pins_pressed, input ready);
    modport sink (input valid, axis_roll, axis_pitch, axis_throttle, axis_yaw,
                  pins_pressed, output ready);
endinterface

interface rcsm_out_if;
    logic                             valid;
    logic                             ready;
    logic [3:0]                       channel_index;
    logic [rcsm_pkg::CHAN_W-1:0]      channel_value;
    logic                             long_range_wanted;
    logic                             last_channel;
    modport source (output valid, channel_index, channel_value, long_range_wanted,
                    last_channel, input ready);
    modport sink (input valid, channel_index, channel_value, long_range_wanted,
                  last_channel, output ready);
endinterface

@@ rtl/core/rcsm_front.sv @@
module rcsm_front #(
    parameter int unsigned EMA_SHIFT = rcsm_pkg::EMA_SHIFT_DEF,
    parameter int unsigned ADC_BITS  = rcsm_pkg::ADC_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    rcsm_in_if.sink              in_ch,
    input  logic [3:0]           debounce_len,
    output logic                 job_valid,
    input  logic                 job_ready,
    output rcsm_pkg::job_t       job
);
    localparam int unsigned PIN_N = rcsm_pkg::PIN_N;
    localparam int unsigned AW = rcsm_pkg::AXIS_W;

    logic [3:0][AW-1:0]   avg_reg;
    logic [3:0][AW-1:0]   avg_next;
    logic                 primed_reg;
    logic [PIN_N-1:0]     stable_reg;
    logic [PIN_N-1:0]     stable_next;
    logic [PIN_N-1:0][3:0] cnt_reg;
    logic [PIN_N-1:0][3:0] cnt_next;
    logic [3:0][AW-1:0]   x;
    logic                 acc;

    assign in_ch.ready = job_ready;
    assign acc = in_ch.valid & job_ready;

    always_comb
    begin
        logic signed [AW+1:0] d;
        logic [AW+1:0]        mag;
        logic [AW+1:0]        stp;
        logic [4:0]           c1;
        x[0] = in_ch.axis_roll     & AW'((1 << ADC_BITS) - 1);
        x[1] = in_ch.axis_pitch    & AW'((1 << ADC_BITS) - 1);
        x[2] = in_ch.axis_throttle & AW'((1 << ADC_BITS) - 1);
        x[3] = in_ch.axis_yaw      & AW'((1 << ADC_BITS) - 1);
        for (int i = 0; i < 4; i++)
        begin
            mag = '0;
            stp = '0;
            d = $signed({2'b00, x[i]}) - $signed({2'b00, avg_reg[i]});
            if (!primed_reg)
                avg_next[i] = x[i];
            else if (d >= 0)
            begin
                stp = (AW+2)'(d) >> EMA_SHIFT;
                avg_next[i] = avg_reg[i] + stp[AW-1:0];
            end
            else
            begin
                mag = (AW+2)'(-d) + (AW+2)'((1 << EMA_SHIFT) - 1);
                stp = mag >> EMA_SHIFT;
                avg_next[i] = avg_reg[i] - stp[AW-1:0];
            end
        end
        for (int p = 0; p < PIN_N; p++)
        begin
            stable_next[p] = stable_reg[p];
            c1 = {1'b0, cnt_reg[p]} + 5'd1;
            if (in_ch.pins_pressed[p] == stable_reg[p])
                cnt_next[p] = 4'd0;
            else if (c1[3:0] >= debounce_len)
            begin
                stable_next[p] = in_ch.pins_pressed[p];
                cnt_next[p] = 4'd0;
            end
            else
                cnt_next[p] = c1[3:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avg_reg    <= '0;
            primed_reg <= 1'b0;
            stable_reg <= '0;
            cnt_reg    <= '0;
        end
        else if (acc)
        begin
            avg_reg    <= avg_next;
            primed_reg <= 1'b1;
            stable_reg <= stable_next;
            cnt_reg    <= cnt_next;
        end
    end

    assign job_valid  = in_ch.valid;
    assign job.avg    = avg_next;
    assign job.stable = stable_next;
endmodule

@@ rtl/core/rcsm_queue.sv @@
module rcsm_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  rcsm_pkg::job_t wr_data,
    output logic           rd_valid,
    input  logic           rd_ready,
    output rcsm_pkg::job_t rd_data
);
    rcsm_pkg::job_t mem_reg [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;
    logic       wr;
    logic       rd;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign wr = wr_valid & wr_ready;
    assign rd = rd_valid & rd_ready;
    assign rd_data = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr)
                wp_reg <= ~wp_reg;
            if (rd)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, rd};
        end
    end
endmodule

@@ rtl/core/rcsm_back.sv @@
module rcsm_back (
    input  logic           clk,
    input  logic           rst_n,
    input  rcsm_pkg::cfg_t cfg,
    input  logic           job_valid,
    output logic           job_ready,
    input  rcsm_pkg::job_t job,
    rcsm_out_if.source     out_ch
);
    localparam int unsigned AW = rcsm_pkg::AXIS_W;
    localparam int unsigned CW = rcsm_pkg::CHAN_W;
    localparam int unsigned DW = rcsm_pkg::DIV_W;

    rcsm_pkg::back_state_t state_reg, state_next;
    rcsm_pkg::job_t        job_reg;
    logic [1:0]            axis_reg;
    logic [3:0][CW-1:0]    stick_reg;
    logic [4:0]            bit_reg;
    logic [DW-1:0]         quo_reg;
    logic [AW:0]           rem_reg;
    logic [AW-1:0]         den_reg;
    logic                  up_reg;
    logic [3:0]            ch_reg;
    logic                  take;

    // setup: deadband and spans
    logic signed [AW+1:0] v, ctr, db, span_lo, span_hi, vc;
    logic [DW-1:0]        num;
    logic                 in_db;
    logic                 setup_mid;
    logic                 setup_up;
    logic [AW-1:0]        setup_den;
    always_comb
    begin
        v   = $signed({2'b00, job_reg.avg[axis_reg]});
        ctr = $signed({2'b00, cfg.cal_center});
        db  = $signed({2'b00, cfg.dead_band});
        span_lo = ctr - $signed({2'b00, cfg.cal_min});
        span_hi = $signed({2'b00, cfg.cal_max}) - ctr;
        in_db = (v > ctr - db) && (v < ctr + db);
        setup_up = (v > ctr);
        vc = v;
        num = '0;
        setup_den = '0;
        setup_mid = in_db;
        if (!setup_up)
        begin
            if (span_lo <= 0)
                setup_mid = 1'b1;
            if (v < $signed({2'b00, cfg.cal_min}))
                vc = $signed({2'b00, cfg.cal_min});
            setup_den = span_lo[AW-1:0];
            num = DW'($unsigned(ctr - vc));
        end
        else
        begin
            if (span_hi <= 0)
                setup_mid = 1'b1;
            if (v > $signed({2'b00, cfg.cal_max}))
                vc = $signed({2'b00, cfg.cal_max});
            setup_den = span_hi[AW-1:0];
            num = DW'($unsigned(vc - ctr));
        end
    end

    // signed product: chan difference may be negative, divide magnitude
    logic                 neg_reg;
    logic signed [CW+1:0] dch;
    always_comb
    begin
        if (!setup_up)
            dch = $signed({2'b0, cfg.chan_middle}) - $signed({2'b0, cfg.chan_low});
        else
            dch = $signed({2'b0, cfg.chan_high}) - $signed({2'b0, cfg.chan_middle});
    end
    logic [CW+1:0] dmag;
    logic [DW-1:0] num_mag;
    always_comb
    begin
        if (dch < 0)
            dmag = $unsigned(-dch);
        else
            dmag = $unsigned(dch);
        num_mag = num * DW'(dmag);
    end

    // restoring division step
    logic [AW+1:0] trial;
    logic [AW:0]   rem_sh;
    always_comb
    begin
        rem_sh = {rem_reg[AW-1:0], quo_reg[DW-1]};
        trial  = {1'b0, rem_sh} - {2'b00, den_reg};
    end

    // combine and clamp
    logic signed [DW+1:0] r;
    logic [CW-1:0]        clamped;
    always_comb
    begin
        if (neg_reg ^ !up_reg)
            r = $signed({2'b0, cfg.chan_middle}) - $signed({2'b0, quo_reg});
        else
            r = $signed({2'b0, cfg.chan_middle}) + $signed({2'b0, quo_reg});
        if (r < $signed({2'b0, cfg.chan_low}))
            r = $signed({2'b0, cfg.chan_low});
        if (r > $signed({2'b0, cfg.chan_high}))
            r = $signed({2'b0, cfg.chan_high});
        clamped = r[CW-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rcsm_pkg::B_IDLE:  if (job_valid) state_next = rcsm_pkg::B_SETUP;
            rcsm_pkg::B_SETUP: state_next = setup_mid ? (axis_reg == 2'd3 ?
                                   rcsm_pkg::B_EMIT : rcsm_pkg::B_SETUP) : rcsm_pkg::B_DIV;
            rcsm_pkg::B_DIV:   if (bit_reg == 5'd0) state_next = rcsm_pkg::B_CLAMP;
            rcsm_pkg::B_CLAMP: state_next = (axis_reg == 2'd3) ? rcsm_pkg::B_EMIT :
                                   rcsm_pkg::B_SETUP;
            rcsm_pkg::B_EMIT:  if (take && ch_reg == 4'd15) state_next = rcsm_pkg::B_IDLE;
            default:           state_next = rcsm_pkg::B_IDLE;
        endcase
    end

    logic [CW-1:0] ch_val;
    always_comb
    begin
        case (ch_reg)
            4'd0, 4'd1, 4'd2, 4'd3: ch_val = stick_reg[ch_reg[1:0]];
            4'd4:  ch_val = job_reg.stable[0] ? cfg.chan_high : cfg.chan_low;
            4'd5:  ch_val = job_reg.stable[1] ? cfg.chan_low :
                            (job_reg.stable[2] ? cfg.chan_high : cfg.chan_middle);
            4'd6:  ch_val = job_reg.stable[3] ? cfg.chan_high : cfg.chan_low;
            4'd7:  ch_val = job_reg.stable[4] ? cfg.chan_high : cfg.chan_low;
            4'd8:  ch_val = cfg.chan_middle;
            4'd9:  ch_val = job_reg.stable[6] ? cfg.chan_low :
                            (job_reg.stable[7] ? cfg.chan_high : cfg.chan_middle);
            default: ch_val = job_reg.stable[ch_reg - 4'd2] ? cfg.chan_high : cfg.chan_low;
        endcase
    end

    assign job_ready = (state_reg == rcsm_pkg::B_IDLE);
    assign take = out_ch.valid & out_ch.ready;

    always_comb
    begin
        out_ch.valid             = (state_reg == rcsm_pkg::B_EMIT);
        out_ch.channel_index     = ch_reg;
        out_ch.channel_value     = ch_val;
        out_ch.long_range_wanted = job_reg.stable[5];
        out_ch.last_channel      = (ch_reg == 4'd15);
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            rcsm_pkg::B_IDLE:
                if (job_valid)
                    job_reg <= job;
            rcsm_pkg::B_SETUP:
            begin
                quo_reg <= num_mag;
                rem_reg <= '0;
                den_reg <= setup_den;
                up_reg  <= setup_up;
                neg_reg <= (dch < 0);
                if (setup_mid)
                    stick_reg[axis_reg] <= cfg.chan_middle;
            end
            rcsm_pkg::B_DIV:
            begin
                if (!trial[AW+1])
                begin
                    rem_reg <= trial[AW:0];
                    quo_reg <= {quo_reg[DW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh;
                    quo_reg <= {quo_reg[DW-2:0], 1'b0};
                end
            end
            rcsm_pkg::B_CLAMP:
                stick_reg[axis_reg] <= clamped;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rcsm_pkg::B_IDLE;
            axis_reg  <= 2'd0;
            bit_reg   <= 5'd0;
            ch_reg    <= 4'd0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                rcsm_pkg::B_IDLE:
                begin
                    axis_reg <= 2'd0;
                    ch_reg   <= 4'd0;
                end
                rcsm_pkg::B_SETUP:
                begin
                    bit_reg <= 5'(DW - 1);
                    if (setup_mid)
                        axis_reg <= axis_reg + 2'd1;
                end
                rcsm_pkg::B_DIV:
                    bit_reg <= bit_reg - 5'd1;
                rcsm_pkg::B_CLAMP:
                    axis_reg <= axis_reg + 2'd1;
                rcsm_pkg::B_EMIT:
                    if (take)
                        ch_reg <= ch_reg + 4'd1;
                default:
                    ch_reg <= ch_reg;
            endcase
        end
    end
endmodule

@@ rtl/core/rc_stick_switch_channel_mapper.sv @@
// channel  direction  payload
// in_ch    sink       four 12-bit stick readings, 14 pressed-pin flags
// out_ch   source     channel index, 11-bit value, range bit, last flag
// cfg      write      eight calibration and debounce registers
//
// each sample yields 16 channel requests; after the idle state the back end visits
// per axis a setup state, plus the divider and clamp states when the axis is scaled,
// then the emit state for every request. the front end filters and debounces in the
// accept cycle and a two-entry queue lets it run ahead.
// rst_n clears filter, debounce and control state and loads register defaults.
// out_ch stalls hold the current request; in_ch stalls only when the queue is full.
module rc_stick_switch_channel_mapper #(
    parameter int unsigned EMA_SHIFT = rcsm_pkg::EMA_SHIFT_DEF,
    parameter int unsigned ADC_BITS  = rcsm_pkg::ADC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    rcsm_in_if.sink                           in_ch,
    rcsm_out_if.source                        out_ch,
    input  logic                              cfg_we,
    input  logic [rcsm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rcsm_pkg::CFG_DATA_W-1:0]   cfg_data
);
    rcsm_pkg::cfg_t cfg_reg;
    rcsm_pkg::job_t fj, bj;
    logic fv, fr, bv, br;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cal_min      <= 12'd100;
            cfg_reg.cal_center   <= 12'd2048;
            cfg_reg.cal_max      <= 12'd3995;
            cfg_reg.dead_band    <= 12'd20;
            cfg_reg.chan_low     <= 11'd172;
            cfg_reg.chan_middle  <= 11'd992;
            cfg_reg.chan_high    <= 11'd1811;
            cfg_reg.debounce_len <= 4'd3;
        end
        else if (cfg_we)
        begin
            case (rcsm_pkg::cfg_idx_t'(cfg_index))
                rcsm_pkg::REG_CAL_MIN:     cfg_reg.cal_min      <= cfg_data;
                rcsm_pkg::REG_CAL_CENTER:  cfg_reg.cal_center   <= cfg_data;
                rcsm_pkg::REG_CAL_MAX:     cfg_reg.cal_max      <= cfg_data;
                rcsm_pkg::REG_DEAD_BAND:   cfg_reg.dead_band    <= cfg_data;
                rcsm_pkg::REG_CHAN_LOW:    cfg_reg.chan_low     <= cfg_data[10:0];
                rcsm_pkg::REG_CHAN_MIDDLE: cfg_reg.chan_middle  <= cfg_data[10:0];
                rcsm_pkg::REG_CHAN_HIGH:   cfg_reg.chan_high    <= cfg_data[10:0];
                rcsm_pkg::REG_DEBOUNCE:    cfg_reg.debounce_len <= cfg_data[3:0];
                default:                   cfg_reg <= cfg_reg;
            endcase
        end
    end

    rcsm_front #(.EMA_SHIFT(EMA_SHIFT), .ADC_BITS(ADC_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .debounce_len(cfg_reg.debounce_len),
        .job_valid(fv), .job_ready(fr), .job(fj)
    );

    rcsm_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr_valid(fv), .wr_ready(fr), .wr_data(fj),
        .rd_valid(bv), .rd_ready(br), .rd_data(bj)
    );

    rcsm_back u_back (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg), .job_valid(bv), .job_ready(br),
        .job(bj), .out_ch(out_ch)
    );
endmodule

@@ rtl/core/rcsm_checker.sv @@
module rcsm_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [3:0] out_index,
    input logic       out_last,
    input logic [10:0] out_value
);
    // last flag marks channel 15 only
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_last == (out_index == 4'd15)))
        else $error("last flag mismatch");

    // channel index advances by one after each taken request but the last
    a_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !out_last) ##1 out_valid |->
        out_index == $past(out_index) + 4'd1)
        else $error("channel order broken");

    // stalled request holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_index) && $stable(out_value)))
        else $error("stalled request changed");
endmodule

bind rc_stick_switch_channel_mapper rcsm_checker u_rcsm_checker (
    .clk(clk), .rst_n(rst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_index(out_ch.channel_index), .out_last(out_ch.last_channel),
    .out_value(out_ch.channel_value)
);
